@@ design/pmq_pkg.sv @@
`timescale 1ns / 1ps

package pmq_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_AGAIN    = 3'd2,
    ST_TIMEDOUT = 3'd3,
    ST_NOENT    = 3'd4,
    ST_TOOBIG   = 3'd5,
    ST_BLOCK    = 3'd6
  } status_t;

  localparam logic       REQ_SEND     = 1'b0;
  localparam logic [1:0] WAIT_NONBLOCK = 2'd0;
  localparam logic [1:0] WAIT_EXPIRED  = 2'd1;

  localparam logic [1:0] CFG_MAX_MESSAGES   = 2'd0;
  localparam logic [1:0] CFG_MAX_MSG_BYTES  = 2'd1;
  localparam logic [1:0] CFG_QUEUE_UNLINKED = 2'd2;

  localparam logic [4:0]  RST_MAX_MESSAGES  = 5'd10;
  localparam logic [13:0] RST_MAX_MSG_BYTES = 14'd8192;

  typedef struct packed {
    logic        req_type;
    logic [14:0] msg_prio;
    logic [13:0] msg_length;
    logic [31:0] payload_ref;
    logic [1:0]  wait_mode;
  } msg_req_t;

  typedef struct packed {
    status_t     status;
    logic [14:0] out_prio;
    logic [13:0] out_len;
    logic [31:0] out_ref;
    logic [4:0]  occupancy;
  } msg_rsp_t;

  // One queued descriptor as held by a cell.
  typedef struct packed {
    logic [14:0] prio;
    logic [13:0] len;
    logic [31:0] pref;
  } entry_t;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage

@@ design/pmq_cell.sv @@
`timescale 1ns / 1ps

module pmq_cell (
  input  logic              clk,
  input  pmq_pkg::cell_cmd_t cmd,
  input  pmq_pkg::entry_t   new_entry,
  input  logic              occupied,
  input  pmq_pkg::entry_t   prev_entry,
  input  logic              prev_greater,
  input  pmq_pkg::entry_t   next_entry,
  output pmq_pkg::entry_t   entry,
  output logic              greater
);

  // Strict compare keeps equal priorities in arrival order.
  assign greater = !occupied || (new_entry.prio > entry.prio);

  always_ff @(posedge clk) begin
    if (cmd.push && greater) begin
      // Take the neighbor's entry when the insert point lies above, else load the new one.
      entry <= prev_greater ? prev_entry : new_entry;
    end else if (cmd.pop) begin
      entry <= next_entry;
    end
  end

endmodule

@@ design/priority_message_queue.sv @@
`timescale 1ns / 1ps

// A response is valid the cycle after its request transfer when the output is free.
// Throughput: one request per cycle while the skid slot is empty; the sorted row of cells inserts or pops in one step.
// A two-entry output stage (register plus skid) takes one more request while a response
// waits; the input then stalls until the output register transfers.
// Reset (rst, synchronous): queue empties, registers return to 10 / 8192 / 0.
// Cell contents are not cleared; only entries below the count are ever read.
module priority_message_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int MAX_MSG_BYTES = 8192
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  pmq_pkg::msg_req_t req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output pmq_pkg::msg_rsp_t rsp_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [13:0]       cfg_data
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers
  logic [4:0]  max_messages;
  logic [13:0] max_msg_bytes;
  logic        queue_unlinked;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // Output register and skid slot
  logic              skid_valid;
  pmq_pkg::msg_rsp_t skid_data;

  pmq_pkg::entry_t    cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_greater;
  logic [QUEUE_DEPTH-1:0] cell_occupied;
  pmq_pkg::entry_t    new_entry;
  pmq_pkg::cell_cmd_t cmd;

  logic              accept;
  logic              bad_len;
  logic              full;
  logic [31:0]       capacity;
  logic [31:0]       occ_wide;
  pmq_pkg::status_t  unavail;
  pmq_pkg::msg_rsp_t result;

  assign cfg_ready = 1'b1;
  assign req_ready = !skid_valid;
  assign accept    = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_messages   <= pmq_pkg::RST_MAX_MESSAGES;
      max_msg_bytes  <= pmq_pkg::RST_MAX_MSG_BYTES;
      queue_unlinked <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pmq_pkg::CFG_MAX_MESSAGES:   max_messages   <= cfg_data[4:0];
        pmq_pkg::CFG_MAX_MSG_BYTES:  max_msg_bytes  <= cfg_data;
        pmq_pkg::CFG_QUEUE_UNLINKED: queue_unlinked <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capacity in use is max_messages clamped to the built depth.
  assign capacity = (32'(max_messages) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH)
                                                            : 32'(max_messages);
  assign full    = 32'(count) >= capacity;
  assign bad_len = (req_data.msg_length == 14'd0) || (req_data.msg_length > max_msg_bytes)
                   || (32'(req_data.msg_length) > 32'(MAX_MSG_BYTES));

  // Full or empty: unlinked first, then wait mode.
  always_comb begin
    if (queue_unlinked) begin
      unavail = pmq_pkg::ST_NOENT;
    end else if (req_data.wait_mode == pmq_pkg::WAIT_NONBLOCK) begin
      unavail = pmq_pkg::ST_AGAIN;
    end else if (req_data.wait_mode == pmq_pkg::WAIT_EXPIRED) begin
      unavail = pmq_pkg::ST_TIMEDOUT;
    end else begin
      unavail = pmq_pkg::ST_BLOCK;
    end
  end

  assign new_entry.prio = req_data.msg_prio;
  assign new_entry.len  = req_data.msg_length;
  assign new_entry.pref = req_data.payload_ref;

  // Decide the step and the response for the request on the input.
  always_comb begin
    cmd        = '0;
    count_next = count;
    result     = '0;
    result.status = pmq_pkg::ST_OK;
    if (req_data.req_type == pmq_pkg::REQ_SEND) begin
      if (bad_len) begin
        result.status = pmq_pkg::ST_INVALID;
      end else if (full) begin
        result.status = unavail;
      end else begin
        cmd.push   = accept;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (count == '0) begin
        result.status = unavail;
      end else begin
        cmd.pop    = accept;
        count_next = count - CNT_W'(1);
        // Drop an oversize head anyway, reporting no descriptor.
        if (cell_entry[0].len > req_data.msg_length) begin
          result.status = pmq_pkg::ST_TOOBIG;
        end else begin
          result.out_prio = cell_entry[0].prio;
          result.out_len  = cell_entry[0].len;
          result.out_ref  = cell_entry[0].pref;
        end
      end
    end
    occ_wide         = 32'(count_next);
    result.occupancy = occ_wide[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Row of cells, head at index 0; each loads from its neighbor on a shift.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pmq_pkg::entry_t prev_e;
    pmq_pkg::entry_t next_e;
    logic            prev_g;

    assign cell_occupied[i] = 32'(i) < 32'(count);

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_g = 1'b0;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
      assign prev_g = cell_greater[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = cell_entry[i];
    end else begin : g_mid
      assign next_e = cell_entry[i+1];
    end

    pmq_cell u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .new_entry    (new_entry),
      .occupied     (cell_occupied[i]),
      .prev_entry   (prev_e),
      .prev_greater (prev_g),
      .next_entry   (next_e),
      .entry        (cell_entry[i]),
      .greater      (cell_greater[i])
    );
  end

  // Output stage: the skid slot catches a response while the register is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rsp_valid || rsp_ready) begin
      rsp_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("skid holds a response while output register is empty");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance count");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not reduce count");

  a_accept_rsp: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("transfer produced no response");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int QD        = 16;
  localparam int MAX_BYTES = 8192;
  localparam int STALL_CAP = 400;   // cycles with no transfer before giving up

  // Request kinds and wait modes that the package leaves unnamed.
  localparam logic       REQ_RECV      = ~pmq_pkg::REQ_SEND;
  localparam logic [1:0] WAIT_INFINITE = 2'd2;
  localparam logic [1:0] WAIT_RELATIVE = 2'd3;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  pmq_pkg::msg_req_t req_data;
  logic              rsp_valid;
  logic              rsp_ready;
  pmq_pkg::msg_rsp_t rsp_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [1:0]        cfg_index;
  logic [13:0]       cfg_data;

  priority_message_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock: low for 1 ns, high for 1 ns.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Queue model: sorted descriptor slots, head at index 0, plus the registers.
  // ---------------------------------------------------------------------------
  pmq_pkg::entry_t   slots [QD];
  int                held;
  logic [4:0]        cap_reg;
  logic [13:0]       bytes_reg;
  logic              unlinked_reg;

  pmq_pkg::msg_rsp_t replies_due[$];   // expected responses, oldest first
  int                errors;
  int                quiet_cycles;

  // Idle controls, changed by the tests.
  int          req_gap_pct;
  int          rsp_stall_pct;
  bit          calm;

  function automatic int capacity();
    return (cap_reg > QD) ? QD : int'(cap_reg);
  endfunction

  // Status for a full queue on send or an empty one on receive.
  function automatic pmq_pkg::status_t blocked_status(logic [1:0] mode);
    if (unlinked_reg)
      return pmq_pkg::ST_NOENT;
    if (mode == pmq_pkg::WAIT_NONBLOCK)
      return pmq_pkg::ST_AGAIN;
    if (mode == pmq_pkg::WAIT_EXPIRED)
      return pmq_pkg::ST_TIMEDOUT;
    return pmq_pkg::ST_BLOCK;
  endfunction

  // Apply one request to the model and return the response it must produce.
  function automatic pmq_pkg::msg_rsp_t predict_reply(pmq_pkg::msg_req_t r);
    pmq_pkg::msg_rsp_t o;
    pmq_pkg::entry_t   head;
    int                pos;
    int                i;
    o = '0;
    o.status = pmq_pkg::ST_OK;
    if (r.req_type == pmq_pkg::REQ_SEND) begin
      if (r.msg_length == 0 || r.msg_length > bytes_reg || r.msg_length > MAX_BYTES) begin
        o.status = pmq_pkg::ST_INVALID;
      end else if (held >= capacity()) begin
        o.status = blocked_status(r.wait_mode);
      end else begin
        // Insert behind every entry of equal or higher priority.
        pos = held;
        for (i = 0; i < held; i++) begin
          if (pos == held && r.msg_prio > slots[i].prio)
            pos = i;
        end
        for (i = held; i > pos; i--)
          slots[i] = slots[i - 1];
        slots[pos].prio = r.msg_prio;
        slots[pos].len  = r.msg_length;
        slots[pos].pref = r.payload_ref;
        held++;
      end
    end else begin
      if (held == 0) begin
        o.status = blocked_status(r.wait_mode);
      end else begin
        // Pop the head; an oversize head is dropped all the same.
        head = slots[0];
        for (i = 1; i < held; i++)
          slots[i - 1] = slots[i];
        held--;
        if (head.len > r.msg_length) begin
          o.status = pmq_pkg::ST_TOOBIG;
        end else begin
          o.out_prio = head.prio;
          o.out_len  = head.len;
          o.out_ref  = head.pref;
        end
      end
    end
    o.occupancy = held[4:0];
    return o;
  endfunction

  task automatic cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check each response transfer, then track config and request
  // transfers. All sampling happens on the pre-edge values.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pmq_pkg::msg_rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("response with nothing outstanding: 0x%0h", rsp_data);
          errors++;
        end else begin
          want = replies_due.pop_front();
          cmp_field("status",    32'(want.status),    32'(rsp_data.status));
          cmp_field("out_prio",  32'(want.out_prio),  32'(rsp_data.out_prio));
          cmp_field("out_len",   32'(want.out_len),   32'(rsp_data.out_len));
          cmp_field("out_ref",   want.out_ref,        rsp_data.out_ref);
          cmp_field("occupancy", 32'(want.occupancy), 32'(rsp_data.occupancy));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pmq_pkg::CFG_MAX_MESSAGES:   cap_reg      = cfg_data[4:0];
          pmq_pkg::CFG_MAX_MSG_BYTES:  bytes_reg    = cfg_data;
          pmq_pkg::CFG_QUEUE_UNLINKED: unlinked_reg = cfg_data[0];
          default: ;
        endcase
      end
      if (req_valid && req_ready)
        replies_due.push_back(predict_reply(req_data));
    end
  end

  // Watchdog: end the run if nothing transfers for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_CAP) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response side back-pressure: random stall bursts.
  initial begin
    rsp_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Present one request and hold it until its transfer. Valid stays high on
  // return so back-to-back requests never toggle it within one step.
  task automatic push_request(pmq_pkg::msg_req_t r);
    if (!calm && req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every outstanding response has arrived.
  task automatic drain_queue();
    req_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write all three registers back to back; call only when idle.
  task automatic program_regs(logic [4:0] cap, logic [13:0] bytes, logic unl);
    logic [1:0]  idx [3];
    logic [13:0] val [3];
    idx[0] = pmq_pkg::CFG_MAX_MESSAGES;   val[0] = 14'(cap);
    idx[1] = pmq_pkg::CFG_MAX_MSG_BYTES;  val[1] = bytes;
    idx[2] = pmq_pkg::CFG_QUEUE_UNLINKED; val[2] = 14'(unl);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic pmq_pkg::msg_req_t mk_req(logic kind, int prio, int len,
                                               logic [31:0] pref, logic [1:0] mode);
    pmq_pkg::msg_req_t r;
    r.req_type    = kind;
    r.msg_prio    = prio[14:0];
    r.msg_length  = len[13:0];
    r.payload_ref = pref;
    r.wait_mode   = mode;
    return r;
  endfunction

  // Random request, mostly well-formed, weighted toward sends by send_pct.
  function automatic pmq_pkg::msg_req_t make_request(int send_pct);
    pmq_pkg::msg_req_t r;
    int                lim;
    int                pick;
    r.req_type    = ($urandom_range(0, 99) < send_pct) ? pmq_pkg::REQ_SEND : REQ_RECV;
    r.payload_ref = $urandom;
    r.wait_mode   = 2'($urandom_range(0, 3));
    // Narrow priorities half the time so ties are common.
    r.msg_prio    = ($urandom_range(0, 1) != 0) ? 15'($urandom_range(0, 7))
                                                : 15'($urandom_range(0, 32767));
    if ($urandom_range(0, 19) == 0)
      r.msg_prio = ($urandom_range(0, 1) != 0) ? 15'h7fff : 15'h0;
    lim  = (bytes_reg > MAX_BYTES) ? MAX_BYTES : int'(bytes_reg);
    pick = $urandom_range(0, 99);
    if (r.req_type == pmq_pkg::REQ_SEND) begin
      if (pick < 6 || lim == 0)
        r.msg_length = 14'd0;
      else if (pick < 12)
        r.msg_length = (lim >= 16383) ? 14'h3fff : 14'($urandom_range(lim + 1, 16383));
      else if (pick < 18)
        r.msg_length = 14'(lim);
      else if (pick < 50)
        r.msg_length = 14'($urandom_range(1, (lim > 64) ? 64 : lim));
      else
        r.msg_length = 14'($urandom_range(1, lim));
    end else begin
      if (pick < 10)
        r.msg_length = 14'd0;
      else if (pick < 20)
        r.msg_length = 14'h3fff;
      else if (pick < 50)
        r.msg_length = 14'($urandom_range(0, 64));
      else
        r.msg_length = 14'($urandom_range(0, MAX_BYTES));
    end
    return r;
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // One random phase under one register setting. Send weight and idling
  // change every 20 requests to alternate fill, drain and mixed traffic.
  task automatic run_phase(int n, logic [4:0] cap, logic [13:0] bytes, logic unl);
    int send_pct;
    drain_queue();
    program_regs(cap, bytes, unl);
    send_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       send_pct = 85;
          1:       send_pct = 50;
          default: send_pct = 20;
        endcase
        req_gap_pct   = pick_idle_pct();
        rsp_stall_pct = pick_idle_pct();
      end
      push_request(make_request(send_pct));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers: empty receives in every wait mode, length limits,
  // extreme fields, priority order, FIFO among equals, oversize heads.
  task automatic test_empty_and_lengths();
    push_request(mk_req(REQ_RECV, 0, 8192, 32'h0, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(REQ_RECV, 0, 8192, 32'h0, pmq_pkg::WAIT_EXPIRED));
    push_request(mk_req(REQ_RECV, 0, 8192, 32'h0, WAIT_INFINITE));
    push_request(mk_req(REQ_RECV, 0, 8192, 32'h0, WAIT_RELATIVE));
    push_request(mk_req(pmq_pkg::REQ_SEND, 9, 0, 32'h1, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 9, 8193, 32'h2, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 9, 16383, 32'h3, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 5, 8192, 32'hffff_ffff, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 32767, 1, 32'h0, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 5, 100, 32'h1234_5678, WAIT_RELATIVE));
    push_request(mk_req(pmq_pkg::REQ_SEND, 0, 7, 32'h55, pmq_pkg::WAIT_EXPIRED));
    push_request(mk_req(REQ_RECV, 32767, 16383, 32'hffff_ffff, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(REQ_RECV, 0, 100, 32'h0, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(REQ_RECV, 0, 8192, 32'h0, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(REQ_RECV, 0, 0, 32'h0, pmq_pkg::WAIT_NONBLOCK));
  endtask

  // Small capacity and length limit, full queue in every wait mode, then
  // zero capacity with an unlinked queue while entries still drain.
  task automatic test_limits();
    drain_queue();
    program_regs(5'd2, 14'd50, 1'b0);
    push_request(mk_req(pmq_pkg::REQ_SEND, 3, 50, 32'ha, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 3, 51, 32'hb, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 3, 1, 32'hc, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 4, 10, 32'hd, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(pmq_pkg::REQ_SEND, 4, 10, 32'hd, pmq_pkg::WAIT_EXPIRED));
    push_request(mk_req(pmq_pkg::REQ_SEND, 4, 10, 32'hd, WAIT_INFINITE));
    push_request(mk_req(pmq_pkg::REQ_SEND, 4, 10, 32'hd, WAIT_RELATIVE));
    drain_queue();
    program_regs(5'd0, 14'd8192, 1'b1);
    push_request(mk_req(pmq_pkg::REQ_SEND, 1, 1, 32'he, WAIT_INFINITE));
    push_request(mk_req(REQ_RECV, 0, 50, 32'h0, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(REQ_RECV, 0, 50, 32'h0, pmq_pkg::WAIT_NONBLOCK));
    push_request(mk_req(REQ_RECV, 0, 50, 32'h0, WAIT_INFINITE));
  endtask

  // Random traffic across register settings, extremes included.
  task automatic test_random_mix();
    run_phase(55, 5'd1, 14'd1, 1'b0);
    run_phase(55, 5'd16, 14'd8192, 1'b0);
    run_phase(55, 5'd31, 14'd16383, 1'b0);
    run_phase(55, 5'd10, 14'd8192, 1'b1);
    run_phase(55, 5'd0, 14'd8192, 1'b0);
    run_phase(55, 5'd3, 14'd500, 1'b0);
    run_phase(55, 5'd16, 14'd8192, 1'b1);
    run_phase(55, 5'd20, 14'd40, 1'b0);
    run_phase(55, 5'($urandom_range(1, 16)), 14'($urandom_range(1, 8192)), 1'b0);
  endtask

  // Closing stretch with no idling on either side.
  task automatic test_steady_stream();
    calm = 1'b1;
    run_phase(55, 5'd16, 14'd8192, 1'b0);
  endtask

  initial begin
    rst          <= 1'b1;
    req_valid    <= 1'b0;
    req_data     <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= pmq_pkg::CFG_MAX_MESSAGES;
    cfg_data     <= '0;
    quiet_cycles <= 0;
    errors        = 0;
    held          = 0;
    cap_reg       = pmq_pkg::RST_MAX_MESSAGES;
    bytes_reg     = pmq_pkg::RST_MAX_MSG_BYTES;
    unlinked_reg  = 1'b0;
    calm          = 1'b0;
    req_gap_pct   = 15;
    rsp_stall_pct = 15;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_lengths();
    test_limits();
    test_random_mix();
    test_steady_stream();

    drain_queue();
    repeat (4) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d responses never arrived", replies_due.size());
      errors++;
    end
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
design/pmq_pkg.sv
design/pmq_cell.sv
design/priority_message_queue.sv
tb/testbench.sv
